// ===== rtl/two_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry package
// Shared widths, constants and the arctangent table used by the block.
// ----------------------------------------------------------------------------
package two_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;

  localparam logic [31:0] DPC_RESET = 32'd337155;
  localparam logic [23:0] ITR_RESET = 24'd249187;

  localparam logic [63:0] Q30_PI          = 64'd3373259426;
  localparam logic [63:0] CORDIC_GAIN_Q30 = 64'd652032874;

  localparam logic [0:0] CFG_DPC = 1'b0;
  localparam logic [0:0] CFG_ITR = 1'b1;

  function automatic logic signed [63:0] atan_q30(input logic [4:0] i);
    logic signed [63:0] v;
    begin
      case (i)
        5'd0:  v = 64'sd843314857;
        5'd1:  v = 64'sd497837829;
        5'd2:  v = 64'sd263043836;
        5'd3:  v = 64'sd133525159;
        5'd4:  v = 64'sd67021687;
        5'd5:  v = 64'sd33543516;
        5'd6:  v = 64'sd16775851;
        5'd7:  v = 64'sd8388437;
        5'd8:  v = 64'sd4194283;
        5'd9:  v = 64'sd2097149;
        default: v = 64'sd1 <<< (5'd30 - i);
      endcase
      return v;
    end
  endfunction

endpackage

// ===== rtl/two_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry divider
// Radix-2 restoring divider, one quotient bit per cycle, 64-bit dividend.
// ----------------------------------------------------------------------------
module two_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  import two_pkg::*;

  logic [63:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;
  logic [33:0] diff;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; dvs_nxt = dvs_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r[31:0], q_r[63]};
    diff = {1'b0, trial} - {2'b00, dvs_r};
    if (start) begin
      q_nxt = dividend; rem_nxt = '0; dvs_nxt = divisor;
      cnt_nxt = 7'd0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[33]) begin
        rem_nxt = diff[32:0];
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quotient = q_r;
endmodule

// ===== rtl/three_wheel_odometry.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-wheel odometry
// Dead-reckoning pose and velocity from three encoder counts per word.
// ----------------------------------------------------------------------------
// Channel | Direction | Contents
// in_     | slave     | tdata: count_front, count_side, count_back, time_ms
// out_    | master    | tdata: pose_x, pose_y, pose_heading, vel_forward,
//         |           |        vel_sideways, vel_turn; tuser: updated
// cfg_    | write     | 0 distance_per_count, 1 inverse_track
//
// Each word passes through the sequencer: three distance steps, motion,
// 26 heading-wrap steps, CORDIC, rounding and pose; then the shared 64-bit
// serial divider forms the three velocities, one after another, before
// out_tvalid rises. With a zero elapsed time a word skips from the distance
// steps straight to the output, with pose and velocities unchanged.
// in_tready is high only in the idle state.
// A finished word waits in the output register; the next input word is taken
// as soon as the result register is free or being taken. Reset is
// synchronous, active low, and clears the pose, velocities and stored counts.
// ----------------------------------------------------------------------------
module three_wheel_odometry #(
  parameter int FRAC_BITS    = two_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = two_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // count_front[31:0], count_side[63:32], count_back[95:64], time_ms[127:96]
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pose_x[31:0], pose_y[63:32], pose_heading[82:64], vel_forward[114:83],
  // vel_sideways[146:115], vel_turn[178:147], zero fill above
  output logic [183:0] out_tdata,
  // updated
  output logic [0:0]   out_tuser,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import two_pkg::*;

  localparam int SH = 30 - FRAC_BITS;
  localparam logic signed [63:0] PI_Q =
    64'sd1 * ((Q30_PI + (64'd1 << (SH - 1))) >> SH);
  localparam logic signed [63:0] HALF_PI = PI_Q / 2;
  localparam logic signed [63:0] TWO_PI = PI_Q * 2;
  localparam int NSTEP = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  // The heading sum stays below 2^41 in magnitude, so whole turns up to
  // 2^26 of them cover the smallest pi that FRAC_BITS allows.
  localparam int WRAP_TOP = 25;

  typedef enum logic [3:0] {
    S_IDLE, S_DIST, S_MOTION, S_HSUM, S_WRAP, S_WFIX, S_FOLD, S_CORDIC, S_ROUND,
    S_MUL, S_POSE, S_VDIV, S_VWAIT, S_OUT
  } state_t;

  state_t state_r;
  logic [31:0] dpc_r, last_t_r, px_r, py_r, elapsed_r;
  logic [23:0] itr_r;
  logic [31:0] lc_r [3];
  logic [31:0] cnt_r [3];
  logic signed [18:0] head_r;
  logic signed [31:0] vel_r [3];
  logic signed [63:0] d_r [3];
  logic signed [63:0] dth_r, fwd_r, side_r, h_r;
  logic signed [63:0] cx_r, cy_r, cz_r, sin_r, cos_r;
  logic signed [63:0] p0_r, p1_r, p2_r, p3_r;
  logic        neg_r, upd_r;
  logic [4:0]  i_r;
  logic [1:0]  k_r;
  logic [31:0] now_r;

  // Shared multiplier operands: magnitude by up to 32-bit value.
  logic [1:0]  k2;
  logic [31:0] dc;
  logic [31:0] dc_mag;
  logic [63:0] dprod;
  logic [63:0] dround;

  // Divider
  logic        dv_start, dv_done;
  logic [63:0] dv_num, dv_q;
  logic signed [63:0] vmot;
  logic [63:0] vmag;

  two_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_num),
    .divisor(elapsed_r), .done(dv_done), .quotient(dv_q)
  );

  function automatic logic signed [63:0] rshift(input logic signed [63:0] v,
                                                input int s);
    logic [63:0] m;
    logic [63:0] r;
    begin
      m = v[63] ? -v : v;
      r = (m + (64'd1 << (s - 1))) >> s;
      return v[63] ? -$signed(r) : $signed(r);
    end
  endfunction

  function automatic logic signed [63:0] fshift(input logic signed [63:0] v,
                                                input logic [4:0] s);
    begin
      return v >>> s;
    end
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [63:0] v);
    begin
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    end
  endfunction

  assign k2 = k_r;
  assign dc = cnt_r[k2] - lc_r[k2];
  assign dc_mag = dc[31] ? -dc : dc;
  assign dprod = {32'd0, dc_mag} * {32'd0, dpc_r};
  assign dround = (dprod + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);

  assign vmot = (k_r == 2'd0) ? fwd_r : (k_r == 2'd1) ? side_r : dth_r;
  assign vmag = vmot[63] ? -vmot : vmot;
  assign dv_num = vmag[53:0] * 64'd1000 + {33'd0, elapsed_r[31:1]};
  assign dv_start = (state_r == S_VDIV);

  assign in_tready = (state_r == S_IDLE) && (!out_tvalid || out_tready);

  always_ff @(posedge clk) begin
    logic signed [63:0] q;
    logic signed [63:0] hh;
    logic signed [63:0] nx;
    logic signed [63:0] tj;
    if (!rst_n) begin
      state_r <= S_IDLE; dpc_r <= DPC_RESET; itr_r <= ITR_RESET;
      lc_r[0] <= '0; lc_r[1] <= '0; lc_r[2] <= '0;
      last_t_r <= '0; head_r <= '0; px_r <= '0; py_r <= '0;
      vel_r[0] <= '0; vel_r[1] <= '0; vel_r[2] <= '0;
      out_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DPC: dpc_r <= cfg_data;
          CFG_ITR: itr_r <= cfg_data[23:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          cnt_r[0] <= in_tdata[31:0];
          cnt_r[1] <= -in_tdata[63:32];
          cnt_r[2] <= -in_tdata[95:64];
          now_r <= in_tdata[127:96];
          elapsed_r <= in_tdata[127:96] - last_t_r;
          upd_r <= (in_tdata[127:96] != last_t_r);
          k_r <= 2'd0;
          state_r <= S_DIST;
        end
        S_DIST: begin
          d_r[k2] <= 64'sd1 * sat(dc[31] ? -$signed(dround) : $signed(dround));
          lc_r[k2] <= cnt_r[k2];
          if (k_r == 2'd2) state_r <= upd_r ? S_MOTION : S_OUT;
          else k_r <= k_r + 2'd1;
        end
        S_MOTION: begin
          dth_r <= rshift(($signed(d_r[0][31:0]) - $signed(d_r[2][31:0])) *
                          $signed({1'b0, itr_r}), 16);
          fwd_r <= rshift(d_r[0] + d_r[2], 1);
          side_r <= d_r[1];
          state_r <= S_HSUM;
        end
        S_HSUM: begin
          h_r <= {{45{head_r[18]}}, head_r} + dth_r;
          i_r <= 5'(WRAP_TOP);
          state_r <= S_WRAP;
        end
        S_WRAP: begin
          // Remove whole turns, largest multiple first, while the heading
          // stays outside the range; one last turn follows.
          tj = TWO_PI <<< i_r;
          if (h_r > PI_Q) begin
            if (h_r - tj > PI_Q) h_r <= h_r - tj;
          end else if (h_r < -PI_Q) begin
            if (h_r + tj < -PI_Q) h_r <= h_r + tj;
          end
          if (i_r == 5'd0) state_r <= S_WFIX;
          else i_r <= i_r - 5'd1;
        end
        S_WFIX: begin
          if (h_r > PI_Q) h_r <= h_r - TWO_PI;
          else if (h_r < -PI_Q) h_r <= h_r + TWO_PI;
          state_r <= S_FOLD;
        end
        S_FOLD: begin
          head_r <= h_r[18:0];
          hh = h_r;
          neg_r <= 1'b0;
          if (hh > HALF_PI) begin hh = hh - PI_Q; neg_r <= 1'b1; end
          else if (hh < -HALF_PI) begin hh = hh + PI_Q; neg_r <= 1'b1; end
          cz_r <= hh <<< SH;
          cx_r <= $signed(CORDIC_GAIN_Q30);
          cy_r <= '0;
          i_r <= '0;
          state_r <= S_CORDIC;
        end
        S_CORDIC: begin
          if (!cz_r[63]) begin
            nx = cx_r - fshift(cy_r, i_r);
            cy_r <= cy_r + fshift(cx_r, i_r);
            cz_r <= cz_r - atan_q30(i_r);
          end else begin
            nx = cx_r + fshift(cy_r, i_r);
            cy_r <= cy_r - fshift(cx_r, i_r);
            cz_r <= cz_r + atan_q30(i_r);
          end
          cx_r <= nx;
          i_r <= i_r + 5'd1;
          if (i_r == 5'(NSTEP - 1)) state_r <= S_ROUND;
        end
        S_ROUND: begin
          cos_r <= neg_r ? -rshift(cx_r, SH) : rshift(cx_r, SH);
          sin_r <= neg_r ? -rshift(cy_r, SH) : rshift(cy_r, SH);
          state_r <= S_MUL;
        end
        S_MUL: begin
          // Motions fit 32 bits and sine and cosine fit FRAC_BITS + 2 bits.
          p0_r <= $signed(fwd_r[31:0]) * $signed(cos_r[FRAC_BITS+1:0]);
          p1_r <= $signed(side_r[31:0]) * $signed(sin_r[FRAC_BITS+1:0]);
          p2_r <= $signed(fwd_r[31:0]) * $signed(sin_r[FRAC_BITS+1:0]);
          p3_r <= $signed(side_r[31:0]) * $signed(cos_r[FRAC_BITS+1:0]);
          state_r <= S_POSE;
        end
        S_POSE: begin
          q = rshift(p0_r - p1_r, FRAC_BITS);
          px_r <= px_r + q[31:0];
          q = rshift(p2_r + p3_r, FRAC_BITS);
          py_r <= py_r + q[31:0];
          last_t_r <= now_r;
          k_r <= 2'd0;
          state_r <= S_VDIV;
        end
        S_VDIV: state_r <= S_VWAIT;
        S_VWAIT: if (dv_done) begin
          q = (dv_q > 64'h80000000) ? 64'sh80000000 : $signed(dv_q);
          vel_r[k2] <= sat(vmot[63] ? -q : q);
          if (k_r == 2'd2) state_r <= S_OUT;
          else begin k_r <= k_r + 2'd1; state_r <= S_VDIV; end
        end
        S_OUT: begin
          out_tvalid <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT) begin
      out_tdata <= {5'd0, vel_r[2], vel_r[1], vel_r[0], head_r, py_r, px_r};
      out_tuser <= upd_r;
    end
  end

endmodule
